### rtl/dds_fsk_frame_modulator_macros.svh
// ---------------------------------------------------------------------------
// DDS FSK frame modulator assertion macros
// Concurrent check macros; they expand to nothing in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef DDS_FSK_FRAME_MODULATOR_MACROS_SVH
`define DDS_FSK_FRAME_MODULATOR_MACROS_SVH

`ifndef SYNTHESIS
// Implication within the same cycle
`define DFM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("dfm check failed");
// Implication checked in the next cycle
`define DFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("dfm check failed");
`else
`define DFM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DFM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/dfm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfm_pkg
// Shared widths, register codes, reset values and the sine lookup.
// ---------------------------------------------------------------------------
package dfm_pkg;

	// Sizing
	localparam int TABLE_ADDR_BITS = 8;
	localparam int FRAME_BITS      = 20;

	localparam int PHASE_W    = 16;
	localparam int SAMPLE_W   = 12;
	localparam int POS_W      = 5;
	localparam int HOLD_W     = 20;
	localparam int PATTERN_W  = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam int ROM_ADDR_W = 8;

	// ROM address bits actually resolved by the phase word
	localparam int ROM_KEEP = (TABLE_ADDR_BITS < ROM_ADDR_W) ? TABLE_ADDR_BITS : ROM_ADDR_W;
	localparam logic [ROM_ADDR_W-1:0] ROM_ADDR_MASK =
		ROM_ADDR_W'(((1 << ROM_KEEP) - 1) << (ROM_ADDR_W - ROM_KEEP));

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BITS - 1);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MARK_STEP     = 3'd0,
		CFG_SPACE_STEP    = 3'd1,
		CFG_HOLD_SAMPLES  = 3'd2,
		CFG_FRAME_PATTERN = 3'd3,
		CFG_SEND_MODE     = 3'd4
	} cfg_reg_t;

	// Register reset values
	localparam logic [PHASE_W-1:0]   RST_MARK_STEP     = 16'd1;
	localparam logic [PHASE_W-1:0]   RST_SPACE_STEP    = 16'd1;
	localparam logic [HOLD_W-1:0]    RST_HOLD_SAMPLES  = 20'd2133;
	localparam logic [PATTERN_W-1:0] RST_FRAME_PATTERN = 20'hFFFFF;

	// Sine midscale and quarter wave floor(1500*sin(pi*k/128)), k = 0..64
	localparam logic [SAMPLE_W-1:0] ROM_MID = 12'd1750;
	localparam logic [10:0] QUARTER [0:64] = '{
		11'd0,    11'd36,   11'd73,   11'd110,  11'd147,  11'd183,  11'd220,  11'd256,
		11'd292,  11'd328,  11'd364,  11'd400,  11'd435,  11'd470,  11'd505,  11'd539,
		11'd574,  11'd607,  11'd641,  11'd674,  11'd707,  11'd739,  11'd771,  11'd802,
		11'd833,  11'd863,  11'd893,  11'd922,  11'd951,  11'd979,  11'd1007, 11'd1034,
		11'd1060, 11'd1086, 11'd1111, 11'd1135, 11'd1159, 11'd1182, 11'd1204, 11'd1226,
		11'd1247, 11'd1267, 11'd1286, 11'd1305, 11'd1322, 11'd1339, 11'd1355, 11'd1371,
		11'd1385, 11'd1399, 11'd1412, 11'd1424, 11'd1435, 11'd1445, 11'd1455, 11'd1463,
		11'd1471, 11'd1477, 11'd1483, 11'd1488, 11'd1492, 11'd1495, 11'd1498, 11'd1499,
		11'd1500
	};

	// Frame sequencer view of the current sample
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             mark;
		logic             frame_end;
	} seq_t;

	// Full-wave sine code from the quarter table; negative half rounds down
	function automatic logic [SAMPLE_W-1:0] dfm_sine(input logic [ROM_ADDR_W-1:0] addr);
		logic [6:0]          k;
		logic [6:0]          kr;
		logic [SAMPLE_W-1:0] qk;
		logic [SAMPLE_W-1:0] qr;
		logic [SAMPLE_W-1:0] res;
		k  = {1'b0, addr[5:0]};
		kr = 7'd64 - k;
		qk = SAMPLE_W'(QUARTER[k]);
		qr = SAMPLE_W'(QUARTER[kr]);
		unique case (addr[7:6])
			2'd0: res = ROM_MID + qk;
			2'd1: res = ROM_MID + qr;
			2'd2: res = ROM_MID - qk - SAMPLE_W'(k != 7'd0);
			default: res = ROM_MID - qr - SAMPLE_W'(kr != 7'd64);
		endcase
		return res;
	endfunction

endpackage

### rtl/dfm_tick_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfm_tick_if
// Input channel: one tick per transfer.
// ---------------------------------------------------------------------------
interface dfm_tick_if;
	logic valid;
	logic ready;
	logic tick;

	modport source (output valid, output tick, input ready);
	modport sink   (input valid, input tick, output ready);
endinterface

### rtl/dfm_sample_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfm_sample_if
// Output channel: one DAC sample and its frame status per transfer.
// ---------------------------------------------------------------------------
interface dfm_sample_if
	import dfm_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] dac_sample;
	logic [POS_W-1:0]    bit_position;
	logic                tone_is_mark;
	logic                frame_end;

	modport source (output valid, output dac_sample, output bit_position,
		output tone_is_mark, output frame_end, input ready);
	modport sink   (input valid, input dac_sample, input bit_position,
		input tone_is_mark, input frame_end, output ready);
endinterface

### rtl/dfm_cfg_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfm_cfg_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
interface dfm_cfg_if
	import dfm_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/dfm_frame_seq.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfm_frame_seq
// Walks the frame pattern: hold counter, bit index, tone choice, frame end.
// ---------------------------------------------------------------------------
module dfm_frame_seq
	import dfm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic                 send_mode,
	input  logic [HOLD_W-1:0]    hold_samples,
	input  logic [PATTERN_W-1:0] frame_pattern,
	output seq_t                 seq
);

	logic [HOLD_W-1:0]    hold_count_q;
	logic [POS_W-1:0]     bit_index_q;
	logic [HOLD_W-1:0]    next_count;
	logic                 bit_done;
	logic [PATTERN_W-1:0] pat_shift;

	// Current bit and its end condition
	always_comb begin
		next_count = hold_count_q + HOLD_W'(1);
		bit_done   = (next_count == hold_samples);
		pat_shift  = frame_pattern >> bit_index_q;
		if (send_mode) begin
			seq.pos       = bit_index_q;
			seq.mark      = pat_shift[0];
			seq.frame_end = bit_done && (bit_index_q == LAST_POS);
		end else begin
			seq.pos       = '0;
			seq.mark      = 1'b1;
			seq.frame_end = 1'b0;
		end
	end

	// Advance the frame position; idle mode holds it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_count_q <= '0;
			bit_index_q  <= '0;
		end else if (advance && send_mode) begin
			if (bit_done) begin
				hold_count_q <= '0;
				bit_index_q  <= (bit_index_q == LAST_POS) ? '0 : bit_index_q + POS_W'(1);
			end else begin
				hold_count_q <= next_count;
			end
		end
	end

endmodule

### rtl/dfm_phase_gen.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfm_phase_gen
// Mark and space phase accumulators and the sine lookup of the chosen tone.
// ---------------------------------------------------------------------------
module dfm_phase_gen
	import dfm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic                use_mark,
	input  logic [PHASE_W-1:0]  mark_step,
	input  logic [PHASE_W-1:0]  space_step,
	output logic [SAMPLE_W-1:0] sample
);

	logic [PHASE_W-1:0]    mark_phase_q;
	logic [PHASE_W-1:0]    space_phase_q;
	logic [PHASE_W-1:0]    phase;
	logic [ROM_ADDR_W-1:0] rom_addr;

	// Look up the sample of the selected accumulator
	always_comb begin
		phase    = use_mark ? mark_phase_q : space_phase_q;
		rom_addr = phase[PHASE_W-1 -: ROM_ADDR_W] & ROM_ADDR_MASK;
		sample   = dfm_sine(rom_addr);
	end

	// Advance only the accumulator whose tone is sent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_phase_q  <= '0;
			space_phase_q <= '0;
		end else if (advance) begin
			if (use_mark) begin
				mark_phase_q <= mark_phase_q + mark_step;
			end else begin
				space_phase_q <= space_phase_q + space_step;
			end
		end
	end

endmodule

### rtl/dds_fsk_frame_modulator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dds_fsk_frame_modulator
// Binary FSK modulator on direct digital synthesis. Every transfer on the
// tick channel yields exactly one sample transfer from the output register:
// the sine lookup of the selected tone sits between the state registers and
// the output register, so one tick is taken per clock cycle as long as
// the sample side keeps draining (the output register frees itself in the
// cycle it is read). A tick of 1 advances the selected tone's phase and the
// frame position; a tick of 0 returns the same sample again. Idle mode sends
// a continuous mark tone; send mode walks the 20-bit frame pattern, each bit
// held for hold_samples samples, and repeats it. Configuration writes are
// always taken and must only be issued while no sample is pending.
// ---------------------------------------------------------------------------
`include "dds_fsk_frame_modulator_macros.svh"

module dds_fsk_frame_modulator
	import dfm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	dfm_tick_if.sink     tick_ch,
	dfm_sample_if.source sample_ch,
	dfm_cfg_if.sink      cfg
);

	logic [PHASE_W-1:0]   mark_step_q;
	logic [PHASE_W-1:0]   space_step_q;
	logic [HOLD_W-1:0]    hold_samples_q;
	logic [PATTERN_W-1:0] frame_pattern_q;
	logic                 send_mode_q;

	logic                 out_valid_q;
	logic [SAMPLE_W-1:0]  dac_q;
	logic [POS_W-1:0]     pos_q;
	logic                 mark_q;
	logic                 end_q;

	logic                 in_xfer;
	logic                 advance;
	seq_t                 seq;
	logic [SAMPLE_W-1:0]  sample;

	// Take a tick whenever the output register is free or being drained
	assign tick_ch.ready = !out_valid_q || sample_ch.ready;
	assign in_xfer       = tick_ch.valid && tick_ch.ready;
	assign advance       = in_xfer && tick_ch.tick;
	assign cfg.ready     = 1'b1;

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_step_q     <= RST_MARK_STEP;
			space_step_q    <= RST_SPACE_STEP;
			hold_samples_q  <= RST_HOLD_SAMPLES;
			frame_pattern_q <= RST_FRAME_PATTERN;
			send_mode_q     <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				CFG_MARK_STEP:     mark_step_q     <= cfg.data[PHASE_W-1:0];
				CFG_SPACE_STEP:    space_step_q    <= cfg.data[PHASE_W-1:0];
				CFG_HOLD_SAMPLES:  hold_samples_q  <= cfg.data[HOLD_W-1:0];
				CFG_FRAME_PATTERN: frame_pattern_q <= cfg.data[PATTERN_W-1:0];
				CFG_SEND_MODE:     send_mode_q     <= cfg.data[0];
				default: ;
			endcase
		end
	end

	dfm_frame_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.send_mode     (send_mode_q),
		.hold_samples  (hold_samples_q),
		.frame_pattern (frame_pattern_q),
		.seq           (seq)
	);

	dfm_phase_gen u_phase (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.use_mark   (seq.mark),
		.mark_step  (mark_step_q),
		.space_step (space_step_q),
		.sample     (sample)
	);

	// Output register valid: set on a tick transfer, drop when drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (sample_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			dac_q  <= sample;
			pos_q  <= seq.pos;
			mark_q <= seq.mark;
			end_q  <= seq.frame_end;
		end
	end

	assign sample_ch.valid        = out_valid_q;
	assign sample_ch.dac_sample   = dac_q;
	assign sample_ch.bit_position = pos_q;
	assign sample_ch.tone_is_mark = mark_q;
	assign sample_ch.frame_end    = end_q;

	// Checks
	`DFM_ASSERT_NEXT(a_xfer_gives_sample, clk, arst_n, in_xfer, out_valid_q)
	`DFM_ASSERT_SAME(a_end_on_last_bit, clk, arst_n, out_valid_q && end_q, pos_q == LAST_POS)
	`DFM_ASSERT_SAME(a_pos_in_frame, clk, arst_n, 1'b1, seq.pos <= LAST_POS)

endmodule
